>>> hw/rtl/grid_vertex_normal_generator_defines.svh
// assertion macros for the grid vertex normal generator checker
`ifndef GRID_VERTEX_NORMAL_GENERATOR_DEFINES_SVH
`define GRID_VERTEX_NORMAL_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk and ignored during reset
`define GVN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and ignored during reset
`define GVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gvn_pkg.sv
// types, constants and helpers for the grid vertex normal generator
`default_nettype none

package gvn_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NEXT,
    ST_TSEL,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_RDD,
    ST_SCALE,
    ST_XMUL,
    ST_XACC,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_DEND,
    ST_OUT
  } state_t;

  localparam int TRI_FRAC  = 24;
  localparam int OUT_FRAC  = 14;
  localparam int NUMW      = 58;
  localparam int SCALE_MAX = 32767;

  // done-flag emission kind: bottom-right vertex of the grid
  localparam logic [1:0] EM_CORNER = 2'd3;

  // triangle corner offsets {drow, dcol}, each 2-bit two's complement
  localparam logic [3:0] TRI_OFS [8][3] = '{
    '{4'hF, 4'hC, 4'h0},
    '{4'hF, 4'h3, 4'h0},
    '{4'hC, 4'hD, 4'h1},
    '{4'hC, 4'h1, 4'h0},
    '{4'h1, 4'h0, 4'h5},
    '{4'h1, 4'h5, 4'h4},
    '{4'h3, 4'h0, 4'h4},
    '{4'h3, 4'h4, 4'h7}
  };

  localparam logic [1:0] OFS_NEG = 2'b11;
  localparam logic [1:0] OFS_POS = 2'b01;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] n;
    n = 33'(-v);
    return v[32] ? n : 33'(v);
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/grid_vertex_normal_generator.sv
// grid vertex normal generator top level
`default_nettype none

// Vertices stream in row-major order; normals come out one row and one column
// behind, with the last row flushed by the last input row. All arithmetic runs
// on one shared 33x33 multiplier, a bit-serial square root and a bit-serial
// divider under one sequencer, so the block takes one vertex at a time and
// stalls its input while working. Each triangle goes through reads, edge
// scaling, cross product, squares, root and three divides; a zero-area one
// skips its root and divides. Each emitted normal sums its T triangles, T
// being the 2 to 8 triangles around the vertex, then takes a root and three
// divides for the final sum; one input causes 0 to 4 normals.
// The line stores start undefined and need no clearing pass. A finished normal
// waits in the output register while the next vertex is accepted.
module grid_vertex_normal_generator #(
  parameter int GRID_MAX = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [6:0]         out_row_index,
  output logic [6:0]         out_col_index,
  output logic               out_run_last,
  output logic               out_grid_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_grid_size
);

  localparam int CW    = $clog2(GRID_MAX);
  localparam int SW    = $clog2(GRID_MAX + 1);
  localparam int DEPTH = 3 * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = gvn_pkg::TRI_FRAC + 1;
  localparam int NW    = gvn_pkg::NUMW;
  localparam int FT    = gvn_pkg::TRI_FRAC;
  localparam int FO    = gvn_pkg::OUT_FRAC;

  // line stores
  logic [31:0] mem_x [DEPTH];
  logic [31:0] mem_y [DEPTH];
  logic [31:0] mem_z [DEPTH];

  gvn_pkg::state_t state_r, state_nxt;
  logic [7:0]    gsize_r, gsize_nxt;
  logic [CW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [1:0]    rslot_r, rslot_nxt;
  logic [CW-1:0] ar_r, ar_nxt, ac_r, ac_nxt;
  logic [1:0]    aslot_r, aslot_nxt;
  logic [3:0]    pend_r, pend_nxt;
  logic [1:0]    em_r, em_nxt;
  logic [3:0]    tri_r, tri_nxt;
  logic [2:0]    j_r, j_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          fin_r, fin_nxt;

  logic signed [31:0] rd_r [3];
  logic signed [31:0] pa_r [3], pa_nxt [3];
  logic signed [31:0] pb_r [3], pb_nxt [3];
  logic signed [32:0] e1_r [3], e1_nxt [3];
  logic signed [32:0] e2_r [3], e2_nxt [3];
  logic [32:0]        m1_r, m1_nxt, m2_r, m2_nxt;
  logic signed [65:0] prod_r, prod_nxt;
  logic signed [32:0] vec_r [3], vec_nxt [3];
  logic signed [32:0] acc_r [3], acc_nxt [3];
  logic signed [15:0] nrm_r [3], nrm_nxt [3];
  logic [63:0]        sq_r, sq_nxt, rv_r, rv_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [31:0]        len_r, len_nxt, rem_r, rem_nxt;
  logic [QW-1:0]      nlo_r, nlo_nxt, q_r, q_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] onx_r, onx_nxt, ony_r, ony_nxt, onz_r, onz_nxt;
  logic [6:0]         orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic               olast_r, olast_nxt, odone_r, odone_nxt;

  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]    vi;

  // effective grid size and derived position data
  logic [SW-1:0] s_eff, smax;
  logic [CW-1:0] r_e, c_e, ex, ez, rd_col;
  logic [1:0]    slot_e, exslot, rd_slot;
  logic          xlo, xhi, zlo, zhi, cell_en;
  logic [3:0]    ofs;
  logic [3:0]    flags;

  always_comb begin
    if (gsize_r < 8'd2) begin
      s_eff = SW'(2);
    end else if (gsize_r > GRID_MAX) begin
      s_eff = SW'(GRID_MAX);
    end else begin
      s_eff = SW'(gsize_r);
    end
    smax = s_eff - 1'b1;
  end

  always_comb begin
    r_e    = (SW'(row_r) >= s_eff) ? '0 : row_r;
    c_e    = (SW'(col_r) >= s_eff) ? '0 : col_r;
    slot_e = (SW'(row_r) >= s_eff) ? 2'd0 : rslot_r;
    flags[0] = (r_e != '0) && (c_e != '0);
    flags[1] = (r_e != '0) && (SW'(c_e) == smax);
    flags[2] = (SW'(r_e) == smax) && (c_e != '0);
    flags[3] = (SW'(r_e) == smax) && (SW'(c_e) == smax);
    waddr  = AW'(slot_e) * AW'(GRID_MAX) + AW'(c_e);
  end

  always_comb begin
    ex      = em_r[1] ? ar_r : ar_r - 1'b1;
    ez      = em_r[0] ? ac_r : ac_r - 1'b1;
    exslot  = em_r[1] ? aslot_r : gvn_pkg::dec3(aslot_r);
    xlo     = (ex != '0);
    zlo     = (ez != '0);
    xhi     = (SW'(ex) < smax);
    zhi     = (SW'(ez) < smax);
    case (tri_r[2:1])
      2'd0:    cell_en = xlo && zlo;
      2'd1:    cell_en = xlo && zhi;
      2'd2:    cell_en = xhi && zhi;
      2'd3:    cell_en = xhi && zlo;
      default: cell_en = 1'b0;
    endcase
    ofs = gvn_pkg::TRI_OFS[tri_r[2:0]][vi];
    case (ofs[3:2])
      gvn_pkg::OFS_NEG: rd_slot = gvn_pkg::dec3(exslot);
      gvn_pkg::OFS_POS: rd_slot = gvn_pkg::inc3(exslot);
      default:          rd_slot = exslot;
    endcase
    case (ofs[1:0])
      gvn_pkg::OFS_NEG: rd_col = ez - 1'b1;
      gvn_pkg::OFS_POS: rd_col = ez + 1'b1;
      default:          rd_col = ez;
    endcase
    raddr = AW'(rd_slot) * AW'(GRID_MAX) + AW'(rd_col);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[waddr] <= in_pos_x;
      mem_y[waddr] <= in_pos_y;
      mem_z[waddr] <= in_pos_z;
    end
    rd_r[0] <= mem_x[raddr];
    rd_r[1] <= mem_y[raddr];
    rd_r[2] <= mem_z[raddr];
  end

  always_comb begin
    logic signed [32:0] mul_a, mul_b;
    logic [32:0]        mg;
    logic [63:0]        sq_sum;
    logic [64:0]        sum65;
    logic [NW-1:0]      num;
    logic [32:0]        r2;
    logic signed [15:0] qs;
    logic signed [32:0] qa;
    logic [1:0]         ia, ib;

    state_nxt = state_r;
    gsize_nxt = gsize_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    rslot_nxt = rslot_r;
    ar_nxt    = ar_r;
    ac_nxt    = ac_r;
    aslot_nxt = aslot_r;
    pend_nxt  = pend_r;
    em_nxt    = em_r;
    tri_nxt   = tri_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    prod_nxt  = prod_r;
    vec_nxt   = vec_r;
    acc_nxt   = acc_r;
    nrm_nxt   = nrm_r;
    sq_nxt    = sq_r;
    rv_nxt    = rv_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    nlo_nxt   = nlo_r;
    q_nxt     = q_r;
    out_valid_nxt = out_valid_r;
    onx_nxt   = onx_r;
    ony_nxt   = ony_r;
    onz_nxt   = onz_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    mem_we    = 1'b0;
    vi        = 2'd0;
    mul_a     = '0;
    mul_b     = '0;
    mg        = '0;
    sq_sum    = '0;
    sum65     = '0;
    num       = '0;
    r2        = '0;
    qs        = '0;
    qa        = '0;
    ia        = 2'd0;
    ib        = 2'd0;

    in_stall  = (state_r != gvn_pkg::ST_IDLE);
    cfg_ready = (state_r == gvn_pkg::ST_IDLE) && !in_valid;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gvn_pkg::ST_IDLE: begin
        if (in_valid) begin
          mem_we    = 1'b1;
          ar_nxt    = r_e;
          ac_nxt    = c_e;
          aslot_nxt = slot_e;
          pend_nxt  = flags;
          if (SW'(c_e) == smax) begin
            col_nxt = '0;
            if (SW'(r_e) == smax) begin
              row_nxt   = '0;
              rslot_nxt = 2'd0;
            end else begin
              row_nxt   = r_e + 1'b1;
              rslot_nxt = gvn_pkg::inc3(slot_e);
            end
          end else begin
            col_nxt   = c_e + 1'b1;
            row_nxt   = r_e;
            rslot_nxt = slot_e;
          end
          if (flags != 4'd0) begin
            state_nxt = gvn_pkg::ST_NEXT;
          end
        end else if (cfg_valid) begin
          gsize_nxt = cfg_grid_size;
          row_nxt   = '0;
          col_nxt   = '0;
          rslot_nxt = 2'd0;
        end
      end

      gvn_pkg::ST_NEXT: begin
        if (pend_r[0]) begin
          em_nxt = 2'd0;
        end else if (pend_r[1]) begin
          em_nxt = 2'd1;
        end else if (pend_r[2]) begin
          em_nxt = 2'd2;
        end else begin
          em_nxt = 2'd3;
        end
        pend_nxt = pend_r & (pend_r - 4'd1);
        for (int k = 0; k < 3; k++) acc_nxt[k] = '0;
        tri_nxt   = 4'd0;
        state_nxt = gvn_pkg::ST_TSEL;
      end

      gvn_pkg::ST_TSEL: begin
        if (tri_r == 4'd8) begin
          fin_nxt   = 1'b1;
          vec_nxt   = acc_r;
          sq_nxt    = '0;
          j_nxt     = 3'd0;
          state_nxt = gvn_pkg::ST_SQMUL;
        end else if (cell_en) begin
          state_nxt = gvn_pkg::ST_RDA;
        end else begin
          tri_nxt = tri_r + 4'd1;
        end
      end

      gvn_pkg::ST_RDA: begin
        vi        = 2'd0;
        state_nxt = gvn_pkg::ST_RDB;
      end

      gvn_pkg::ST_RDB: begin
        vi        = 2'd1;
        pa_nxt    = rd_r;
        state_nxt = gvn_pkg::ST_RDC;
      end

      gvn_pkg::ST_RDC: begin
        vi        = 2'd2;
        pb_nxt    = rd_r;
        state_nxt = gvn_pkg::ST_RDD;
      end

      gvn_pkg::ST_RDD: begin
        m1_nxt = '0;
        m2_nxt = '0;
        for (int k = 0; k < 3; k++) begin
          e1_nxt[k] = 33'(pb_r[k]) - 33'(pa_r[k]);
          e2_nxt[k] = 33'(rd_r[k]) - 33'(pa_r[k]);
        end
        for (int k = 0; k < 3; k++) begin
          if (gvn_pkg::mag33(e1_nxt[k]) > m1_nxt) m1_nxt = gvn_pkg::mag33(e1_nxt[k]);
          if (gvn_pkg::mag33(e2_nxt[k]) > m2_nxt) m2_nxt = gvn_pkg::mag33(e2_nxt[k]);
        end
        state_nxt = gvn_pkg::ST_SCALE;
      end

      // block scaling, one bit of shift per cycle on each edge
      gvn_pkg::ST_SCALE: begin
        if (m1_r > 33'(gvn_pkg::SCALE_MAX)) begin
          m1_nxt = m1_r >> 1;
          for (int k = 0; k < 3; k++) e1_nxt[k] = e1_r[k] >>> 1;
        end
        if (m2_r > 33'(gvn_pkg::SCALE_MAX)) begin
          m2_nxt = m2_r >> 1;
          for (int k = 0; k < 3; k++) e2_nxt[k] = e2_r[k] >>> 1;
        end
        if ((m1_r <= 33'(gvn_pkg::SCALE_MAX)) && (m2_r <= 33'(gvn_pkg::SCALE_MAX))) begin
          j_nxt     = 3'd0;
          state_nxt = gvn_pkg::ST_XMUL;
        end
      end

      gvn_pkg::ST_XMUL: begin
        case (j_r)
          3'd0:    begin ia = 2'd1; ib = 2'd2; end
          3'd1:    begin ia = 2'd2; ib = 2'd1; end
          3'd2:    begin ia = 2'd2; ib = 2'd0; end
          3'd3:    begin ia = 2'd0; ib = 2'd2; end
          3'd4:    begin ia = 2'd0; ib = 2'd1; end
          default: begin ia = 2'd1; ib = 2'd0; end
        endcase
        mul_a     = e1_r[ia];
        mul_b     = e2_r[ib];
        prod_nxt  = mul_a * mul_b;
        state_nxt = gvn_pkg::ST_XACC;
      end

      gvn_pkg::ST_XACC: begin
        if (!j_r[0]) begin
          vec_nxt[j_r[2:1]] = prod_r[32:0];
        end else begin
          vec_nxt[j_r[2:1]] = vec_r[j_r[2:1]] - prod_r[32:0];
        end
        if (j_r == 3'd5) begin
          fin_nxt   = 1'b0;
          sq_nxt    = '0;
          j_nxt     = 3'd0;
          state_nxt = gvn_pkg::ST_SQMUL;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = gvn_pkg::ST_XMUL;
        end
      end

      gvn_pkg::ST_SQMUL: begin
        mul_a     = vec_r[j_r[1:0]];
        mul_b     = vec_r[j_r[1:0]];
        prod_nxt  = mul_a * mul_b;
        state_nxt = gvn_pkg::ST_SQACC;
      end

      gvn_pkg::ST_SQACC: begin
        sq_sum = sq_r + prod_r[63:0];
        sq_nxt = sq_sum;
        if (j_r == 3'd2) begin
          if (sq_sum == '0) begin
            // zero-length vector stays zero
            if (fin_r) begin
              for (int k = 0; k < 3; k++) nrm_nxt[k] = '0;
              state_nxt = gvn_pkg::ST_OUT;
            end else begin
              tri_nxt   = tri_r + 4'd1;
              state_nxt = gvn_pkg::ST_TSEL;
            end
          end else begin
            rv_nxt    = sq_sum;
            root_nxt  = '0;
            bit_nxt   = 64'd1 << 62;
            cnt_nxt   = 5'd31;
            state_nxt = gvn_pkg::ST_SQRT;
          end
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = gvn_pkg::ST_SQMUL;
        end
      end

      gvn_pkg::ST_SQRT: begin
        sum65 = {1'b0, root_r} + {1'b0, bit_r};
        if ({1'b0, rv_r} >= sum65) begin
          rv_nxt   = rv_r - sum65[63:0];
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == 5'd0) begin
          len_nxt   = root_nxt[31:0];
          j_nxt     = 3'd0;
          state_nxt = gvn_pkg::ST_DINIT;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      // rounded numerator; its top part is already below the divisor
      gvn_pkg::ST_DINIT: begin
        mg = gvn_pkg::mag33(vec_r[j_r[1:0]]);
        if (fin_r) begin
          num     = (NW'(mg) << FO) + NW'(len_r >> 1);
          rem_nxt = 32'(num >> (FO + 1));
          nlo_nxt = {num[FO:0], {(FT - FO){1'b0}}};
          cnt_nxt = 5'(FO);
        end else begin
          num     = (NW'(mg) << FT) + NW'(len_r >> 1);
          rem_nxt = 32'(num >> (FT + 1));
          nlo_nxt = num[FT:0];
          cnt_nxt = 5'(FT);
        end
        q_nxt     = '0;
        state_nxt = gvn_pkg::ST_DIV;
      end

      gvn_pkg::ST_DIV: begin
        r2 = {rem_r, nlo_r[QW-1]};
        if (r2 >= {1'b0, len_r}) begin
          rem_nxt = 32'(r2 - {1'b0, len_r});
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = r2[31:0];
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        nlo_nxt = nlo_r << 1;
        if (cnt_r == 5'd0) begin
          state_nxt = gvn_pkg::ST_DEND;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      gvn_pkg::ST_DEND: begin
        qs = 16'(q_r);
        qa = 33'(q_r);
        if (fin_r) begin
          nrm_nxt[j_r[1:0]] = vec_r[j_r[1:0]][32] ? -qs : qs;
        end else begin
          acc_nxt[j_r[1:0]] = acc_r[j_r[1:0]] + (vec_r[j_r[1:0]][32] ? -qa : qa);
        end
        if (j_r == 3'd2) begin
          if (fin_r) begin
            state_nxt = gvn_pkg::ST_OUT;
          end else begin
            tri_nxt   = tri_r + 4'd1;
            state_nxt = gvn_pkg::ST_TSEL;
          end
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = gvn_pkg::ST_DINIT;
        end
      end

      gvn_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          onx_nxt   = nrm_r[0];
          ony_nxt   = nrm_r[1];
          onz_nxt   = nrm_r[2];
          orow_nxt  = 7'(ex);
          ocol_nxt  = 7'(ez);
          olast_nxt = (pend_r == 4'd0);
          odone_nxt = (em_r == gvn_pkg::EM_CORNER);
          state_nxt = (pend_r == 4'd0) ? gvn_pkg::ST_IDLE : gvn_pkg::ST_NEXT;
        end
      end

      default: begin
        state_nxt = gvn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gvn_pkg::ST_IDLE;
      gsize_r     <= 8'd17;
      row_r       <= '0;
      col_r       <= '0;
      rslot_r     <= 2'd0;
      pend_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gsize_r     <= gsize_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      rslot_r     <= rslot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ar_r    <= ar_nxt;
    ac_r    <= ac_nxt;
    aslot_r <= aslot_nxt;
    em_r    <= em_nxt;
    tri_r   <= tri_nxt;
    j_r     <= j_nxt;
    cnt_r   <= cnt_nxt;
    fin_r   <= fin_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    e1_r    <= e1_nxt;
    e2_r    <= e2_nxt;
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    prod_r  <= prod_nxt;
    vec_r   <= vec_nxt;
    acc_r   <= acc_nxt;
    nrm_r   <= nrm_nxt;
    sq_r    <= sq_nxt;
    rv_r    <= rv_nxt;
    root_r  <= root_nxt;
    bit_r   <= bit_nxt;
    len_r   <= len_nxt;
    rem_r   <= rem_nxt;
    nlo_r   <= nlo_nxt;
    q_r     <= q_nxt;
    onx_r   <= onx_nxt;
    ony_r   <= ony_nxt;
    onz_r   <= onz_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_normal_x  = onx_r;
  assign out_normal_y  = ony_r;
  assign out_normal_z  = onz_r;
  assign out_row_index = orow_r;
  assign out_col_index = ocol_r;
  assign out_run_last  = olast_r;
  assign out_grid_done = odone_r;

endmodule

`default_nettype wire

>>> hw/rtl/gvn_checker.sv
// port-level checker for the grid vertex normal generator, with its bind
`default_nettype none
`include "grid_vertex_normal_generator_defines.svh"

module gvn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] in_pos_x,
  input logic signed [31:0] in_pos_y,
  input logic signed [31:0] in_pos_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_normal_y,
  input logic signed [15:0] out_normal_z,
  input logic [6:0]         out_row_index,
  input logic [6:0]         out_col_index,
  input logic               out_run_last,
  input logic               out_grid_done,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [7:0]         cfg_grid_size
);

  `GVN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_normal_x) && $stable(out_row_index) && $stable(out_col_index), "stalled normal changed")

  `GVN_ASSERT_SAME(a_norm_range, out_valid, out_normal_x >= -16'sd16384 && out_normal_x <= 16'sd16384 && out_normal_y >= -16'sd16384 && out_normal_y <= 16'sd16384 && out_normal_z >= -16'sd16384 && out_normal_z <= 16'sd16384, "normal component out of unit range")

  `GVN_ASSERT_SAME(a_done_corner, out_valid && out_grid_done, out_run_last && out_row_index == out_col_index, "grid done not on last corner transaction")

  `GVN_ASSERT_SAME(a_cfg_idle, cfg_valid && cfg_ready, !in_stall && !in_valid, "config taken while busy")

endmodule

bind grid_vertex_normal_generator gvn_checker u_gvn_checker (.*);

`default_nettype wire

>>> verif/tb_grid_vertex_normal_generator.sv
// self-checking testbench for the grid vertex normal generator
`timescale 1ns / 1ps

module tb_grid_vertex_normal_generator;

  localparam int GRID_MAX   = 128;
  localparam int NORM_FRAC  = 14;
  localparam int FACE_FRAC  = 24;
  localparam int EDGE_LIMIT = 32767;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE     = 3000;
  localparam int ITEM_GOAL  = 320;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [6:0]         row;
    logic [6:0]         col;
    logic               last;
    logic               done;
  } normal_t;

  typedef struct {
    bit          do_cfg;
    bit [7:0]    cfg_val;
    bit          zero_normal;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic signed [15:0] out_normal_z;
  logic [6:0]         out_row_index;
  logic [6:0]         out_col_index;
  logic               out_run_last;
  logic               out_grid_done;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_grid_size = '0;

  grid_vertex_normal_generator #(.GRID_MAX(GRID_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_row_index(out_row_index),
    .out_col_index(out_col_index), .out_run_last(out_run_last),
    .out_grid_done(out_grid_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_grid_size(cfg_grid_size)
  );

  always #5 clk = ~clk;

  // predictor state
  longint  row_x [3*GRID_MAX];
  longint  row_y [3*GRID_MAX];
  longint  row_z [3*GRID_MAX];
  int      pred_row, pred_col;
  bit [7:0] pred_size;

  normal_t   normal_q [$];
  stim_row_t dir_rows [$];

  int  n_items, n_normals, n_cfg, n_errors, n_mismatch, idle_cycles;
  bit  quiet, hold_off, zero_next, hold_used;

  function automatic int eff_size();
    if (pred_size < 2) return 2;
    if (pred_size > GRID_MAX) return GRID_MAX;
    return pred_size;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r = 0;
    bit [63:0] b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v, int frac);
    vec3_t     o;
    bit [63:0] sq = 0;
    bit [63:0] len, m, q;
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      sq += m * m;
    end
    if (sq == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    len = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      m = v[k] < 0 ? -v[k] : v[k];
      q = ((m << frac) + len / 2) / len;
      o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic vec3_t grid_point(int i, int j);
    vec3_t p;
    int    k = (i % 3) * GRID_MAX + (j % GRID_MAX);
    p[0] = row_x[k];
    p[1] = row_y[k];
    p[2] = row_z[k];
    return p;
  endfunction

  // edge difference, block-scaled so every component fits 16 bits
  function automatic vec3_t scaled_edge(vec3_t a, vec3_t b);
    vec3_t     e;
    bit [63:0] m = 0;
    bit [63:0] mk;
    int        s = 0;
    for (int k = 0; k < 3; k++) begin
      e[k] = b[k] - a[k];
      mk = e[k] < 0 ? -e[k] : e[k];
      if (mk > m) m = mk;
    end
    while ((m >> s) > EDGE_LIMIT) s++;
    for (int k = 0; k < 3; k++) e[k] = e[k] >>> s;
    return e;
  endfunction

  function automatic vec3_t face_normal(int ai, int aj, int bi, int bj, int ci, int cj);
    vec3_t a, e1, e2, t;
    a  = grid_point(ai, aj);
    e1 = scaled_edge(a, grid_point(bi, bj));
    e2 = scaled_edge(a, grid_point(ci, cj));
    t[0] = e1[1] * e2[2] - e1[2] * e2[1];
    t[1] = e1[2] * e2[0] - e1[0] * e2[2];
    t[2] = e1[0] * e2[1] - e1[1] * e2[0];
    return unit_vec(t, FACE_FRAC);
  endfunction

  function automatic normal_t vertex_normal(int x, int z, int s, bit done);
    vec3_t   acc = '{0, 0, 0};
    vec3_t   f[$];
    vec3_t   n;
    normal_t r;
    if (x > 0 && z > 0) begin
      f.push_back(face_normal(x-1, z-1, x-1, z, x, z));
      f.push_back(face_normal(x-1, z-1, x, z-1, x, z));
    end
    if (x > 0 && z < s - 1) begin
      f.push_back(face_normal(x-1, z, x-1, z+1, x, z+1));
      f.push_back(face_normal(x-1, z, x, z+1, x, z));
    end
    if (x < s - 1 && z < s - 1) begin
      f.push_back(face_normal(x, z+1, x, z, x+1, z+1));
      f.push_back(face_normal(x, z+1, x+1, z+1, x+1, z));
    end
    if (x < s - 1 && z > 0) begin
      f.push_back(face_normal(x, z-1, x, z, x+1, z));
      f.push_back(face_normal(x, z-1, x+1, z, x+1, z-1));
    end
    foreach (f[i]) for (int k = 0; k < 3; k++) acc[k] += f[i][k];
    n = unit_vec(acc, NORM_FRAC);
    r.nx = n[0][15:0];
    r.ny = n[1][15:0];
    r.nz = n[2][15:0];
    r.row = x[6:0];
    r.col = z[6:0];
    r.last = 1'b0;
    r.done = done;
    return r;
  endfunction

  // store one vertex and queue the normals it completes
  task automatic predict_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int      s = eff_size();
    int      r = pred_row;
    int      c = pred_col;
    int      k;
    normal_t got [$];
    if (r >= s) r = 0;
    if (c >= s) c = 0;
    k = (r % 3) * GRID_MAX + c;
    row_x[k] = longint'(signed'(px));
    row_y[k] = longint'(signed'(py));
    row_z[k] = longint'(signed'(pz));
    if (r > 0 && c > 0) got.push_back(vertex_normal(r-1, c-1, s, 0));
    if (r > 0 && c == s - 1) got.push_back(vertex_normal(r-1, s-1, s, 0));
    if (r == s - 1 && c > 0) got.push_back(vertex_normal(s-1, c-1, s, 0));
    if (r == s - 1 && c == s - 1) got.push_back(vertex_normal(s-1, s-1, s, 1));
    if (got.size() > 0) got[got.size()-1].last = 1'b1;
    foreach (got[i]) begin
      // a fully degenerate neighborhood gives the zero normal
      if (zero_next) begin
        got[i].nx = 0;
        got[i].ny = 0;
        got[i].nz = 0;
      end
      normal_q.push_back(got[i]);
    end
    c++;
    if (c >= s) begin
      c = 0;
      r++;
      if (r >= s) r = 0;
    end
    pred_row = r;
    pred_col = c;
  endtask

  // valid stays up after the transaction; the caller drops it before anything else
  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (in_stall);
    predict_vertex(px, py, pz);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    wait (normal_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_grid_size(bit [7:0] v);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_grid_size <= v;
    do @(posedge clk); while (!cfg_ready);
    pred_size = v;
    pred_row = 0;
    pred_col = 0;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(bit do_cfg, bit [7:0] cv, bit zn,
                         logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    stim_row_t t;
    t.do_cfg = do_cfg;
    t.cfg_val = cv;
    t.zero_normal = zn;
    t.px = px;
    t.py = py;
    t.pz = pz;
    dir_rows.push_back(t);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // one grid of well-formed positions, partly replaced by noise
  task automatic run_grid(int s, int n_vert);
    int          step, amp;
    int          r, c;
    logic [31:0] px, py, pz;
    step = $urandom_range(1, 4096) * 64;
    amp  = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(4, 22);
    for (int i = 0; i < n_vert; i++) begin
      r = (i / s) % s;
      c = i % s;
      if ($urandom_range(0, 15) == 0) begin
        px = rand_word();
        py = rand_word();
        pz = rand_word();
      end else begin
        px = c * step + $urandom_range(0, 255) - 128;
        pz = r * step + $urandom_range(0, 255) - 128;
        py = $urandom_range(0, (1 << amp) - 1) - (1 << (amp - 1));
      end
      if (n_items > ITEM_GOAL - 40) quiet = 1'b1;
      send_vertex(px, py, pz);
    end
  endtask

  // receiver stall bursts, plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (2500) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_normals++;
      if (normal_q.size() == 0) begin
        n_errors++;
        if (n_mismatch++ < 10)
          $display("unexpected normal at row %0d col %0d", out_row_index, out_col_index);
      end else begin
        e = normal_q.pop_front();
        if (out_normal_x !== e.nx || out_normal_y !== e.ny || out_normal_z !== e.nz ||
            out_row_index !== e.row || out_col_index !== e.col ||
            out_run_last !== e.last || out_grid_done !== e.done) begin
          n_errors++;
          if (n_mismatch++ < 10)
            $display({"mismatch exp n=(%0d,%0d,%0d) rc=(%0d,%0d) l=%0b d=%0b",
                      " got n=(%0d,%0d,%0d) rc=(%0d,%0d) l=%0b d=%0b"},
                     e.nx, e.ny, e.nz, e.row, e.col, e.last, e.done,
                     out_normal_x, out_normal_y, out_normal_z, out_row_index,
                     out_col_index, out_run_last, out_grid_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int s;
    for (int k = 0; k < 3 * GRID_MAX; k++) begin
      row_x[k] = 0;
      row_y[k] = 0;
      row_z[k] = 0;
    end
    pred_row = 0;
    pred_col = 0;
    pred_size = 17;

    // flat zero grid, then extreme and small coordinates at clamped sizes, then a 3x3 grid
    add_row(1, 8'd2, 1, 0, 0, 0);
    add_row(0, 0, 1, 0, 0, 0);
    add_row(0, 0, 1, 0, 0, 0);
    add_row(0, 0, 1, 0, 0, 0);
    add_row(1, 8'd0, 0, 32'h7fffffff, 32'h80000000, 32'h00000000);
    add_row(0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    add_row(0, 0, 0, 32'h00000000, 32'h80000000, 32'h80000000);
    add_row(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    add_row(1, 8'd1, 0, 0, 0, 0);
    add_row(0, 0, 0, 32'h00010000, 0, 0);
    add_row(0, 0, 0, 0, 0, 32'h00010000);
    add_row(0, 0, 0, 32'h00010000, 32'hffff0000, 32'h00010000);
    for (int i = 0; i < 9; i++)
      add_row(i == 0, 8'd3, 0, (i % 3) << 16, (i == 4) ? 32'h00020000 : 0, (i / 3) << 16);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) write_grid_size(dir_rows[i].cfg_val);
      zero_next = dir_rows[i].zero_normal;
      send_vertex(dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz);
    end
    zero_next = 1'b0;

    // largest sizes: a clamped 255 grid up to its first normal, then a short 128 grid with none
    write_grid_size(8'd255);
    run_grid(GRID_MAX, GRID_MAX + 2);
    write_grid_size(8'd128);
    run_grid(GRID_MAX, 3);

    while (n_items < ITEM_GOAL) begin
      s = $urandom_range(2, 6);
      write_grid_size(s[7:0]);
      if (n_items > 200 && !hold_used) begin
        hold_off = 1'b1;
        hold_used = 1'b1;
      end
      case ($urandom_range(0, 5))
        0:       run_grid(s, s * s + s * $urandom_range(1, s));
        1:       run_grid(s, $urandom_range(1, s * s - 1));
        default: run_grid(s, s * s);
      endcase
    end

    in_valid <= 1'b0;
    wait (normal_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
    $display("sent %0d vertices over %0d grid size writes, checked %0d normals",
             n_items, n_cfg, n_normals);
    $display("covered clamped sizes, extreme coordinates, degenerate cells and wraparound");
    if (n_errors == 0 && normal_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d normals missing", n_errors, normal_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/gvn_pkg.sv
hw/rtl/grid_vertex_normal_generator.sv
hw/rtl/gvn_checker.sv
verif/tb_grid_vertex_normal_generator.sv
